FILE: rtl/fifo_queue_with_search_macros.svh
// Assertion macros for the queue RTL, used by fqs_datapath.
// Expects clk and rst_n in scope at the point of use.
`ifndef FIFO_QUEUE_WITH_SEARCH_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define FQS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FQS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FQS_ASSERT(lbl, cond, msg)
`define FQS_ASSERT_IMPL(lbl, ante, cons, msg)
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/fqs_pkg.sv
`timescale 1ns / 1ps
// Types and codes for the FIFO queue with search.
// No dependencies.
package fqs_pkg;

    localparam int DATA_W = 32;

    typedef logic [1:0] command_t;
    typedef logic [2:0] status_t;
    typedef logic [1:0] sel_t;

    localparam command_t CMD_ENQ  = 2'd0;
    localparam command_t CMD_CALL = 2'd1;
    localparam command_t CMD_SRCH = 2'd2;

    localparam status_t ST_STORED   = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_LISTED   = 3'd2;
    localparam status_t ST_REMOVED  = 3'd3;
    localparam status_t ST_EMPTY    = 3'd4;
    localparam status_t ST_FOUND    = 3'd5;
    localparam status_t ST_NOTFOUND = 3'd6;

    localparam sel_t SEL_ZERO  = 2'd0;
    localparam sel_t SEL_RDATA = 2'd1;
    localparam sel_t SEL_HEAD  = 2'd2;

    typedef struct packed {
        logic    enq_write;
        logic    walk_start;
        logic    rd_first;
        logic    rd_adv;
        logic    save_head;
        logic    deq;
        logic    emit;
        status_t emit_status;
        sel_t    emit_sel;
        logic    emit_last;
    } fqs_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic at_end;
        logic first;
        logic out_free;
    } fqs_stat_t;

endpackage

FILE: rtl/fqs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fqs_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer for the FIFO queue with search.
// Depends on fqs_pkg; drives fqs_datapath through fqs_ctl_t.
module fqs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  fqs_pkg::command_t command,
    input  fqs_pkg::fqs_stat_t stat,
    output fqs_pkg::fqs_ctl_t ctl
);
    import fqs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_REM  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    command_t   op_reg, op_next;
    status_t    res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_ENQ;
            res_reg   <= ST_STORED;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            res_reg   <= res_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (command == CMD_ENQ)
                    begin
                        if (stat.full)
                        begin
                            res_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.enq_write = 1'b1;
                            res_next      = ST_STORED;
                        end
                        state_next = S_EMIT;
                    end
                    else if (command inside {CMD_CALL, CMD_SRCH})
                    begin
                        op_next = command;
                        if (stat.empty)
                        begin
                            res_next   = ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            ctl.walk_start = 1'b1;
                            state_next     = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                ctl.rd_first = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                if (op_reg == CMD_CALL)
                begin
                    if (stat.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_LISTED;
                        ctl.emit_sel    = SEL_RDATA;
                        ctl.save_head   = stat.first;
                        if (stat.at_end)
                        begin
                            state_next = S_REM;
                        end
                        else
                        begin
                            ctl.rd_adv = 1'b1;
                        end
                    end
                end
                else if (stat.match)
                begin
                    if (stat.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_FOUND;
                        ctl.emit_sel    = SEL_RDATA;
                        ctl.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.at_end)
                begin
                    if (stat.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_NOTFOUND;
                        ctl.emit_sel    = SEL_ZERO;
                        ctl.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ctl.rd_adv = 1'b1;
                end
            end
            S_REM:
            begin
                if (stat.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = ST_REMOVED;
                    ctl.emit_sel    = SEL_HEAD;
                    ctl.emit_last   = 1'b1;
                    ctl.deq         = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = res_reg;
                    ctl.emit_sel    = SEL_ZERO;
                    ctl.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/fqs_datapath.sv
`timescale 1ns / 1ps
// Ring pointers, entry RAM, walk pointer and output register of the queue.
// Depends on fqs_pkg and fqs_ram; controlled by fqs_ctrl.
`include "fifo_queue_with_search_macros.svh"
module fqs_datapath #(
    parameter int DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [fqs_pkg::DATA_W-1:0] value,
    input  fqs_pkg::fqs_ctl_t                 ctl,
    output fqs_pkg::fqs_stat_t                stat,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output fqs_pkg::status_t                  status,
    output logic signed [fqs_pkg::DATA_W-1:0] data_out,
    output logic                              last
);
    import fqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        ring_next = (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    logic [AW-1:0]     head_reg, tail_reg, ptr_reg;
    logic [CW-1:0]     count_reg, idx_reg;
    logic [DATA_W-1:0] key_reg, head_val_reg, rdata, sel_data;
    logic [AW-1:0]     ptr_inc, raddr;
    logic              re;
    logic              out_valid_reg, out_last_reg;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_data_reg;

    assign ptr_inc = ring_next(ptr_reg);
    assign raddr   = ctl.rd_adv ? ptr_inc : ptr_reg;
    assign re      = ctl.rd_first | ctl.rd_adv;

    fqs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ctl.enq_write),
        .waddr(tail_reg),
        .wdata(value),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.match    = (rdata == key_reg);
    assign stat.at_end   = ((idx_reg + CW'(1)) == count_reg);
    assign stat.first    = (idx_reg == '0);
    assign stat.out_free = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctl.enq_write)
            begin
                tail_reg <= ring_next(tail_reg);
            end
            if (ctl.deq)
            begin
                head_reg <= ring_next(head_reg);
            end
            if (ctl.enq_write && !ctl.deq)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (ctl.deq && !ctl.enq_write)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.walk_start)
        begin
            ptr_reg <= head_reg;
            idx_reg <= '0;
            key_reg <= value;
        end
        else if (ctl.rd_adv)
        begin
            ptr_reg <= ptr_inc;
            idx_reg <= idx_reg + CW'(1);
        end
        if (ctl.save_head)
        begin
            head_val_reg <= rdata;
        end
    end

    always_comb
    begin
        case (ctl.emit_sel)
            SEL_RDATA: sel_data = rdata;
            SEL_HEAD:  sel_data = head_val_reg;
            default:   sel_data = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_status_reg <= ctl.emit_status;
            out_data_reg   <= sel_data;
            out_last_reg   <= ctl.emit_last;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data_out  = out_data_reg;
    assign last      = out_last_reg;

    `FQS_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "entry count above depth")
    `FQS_ASSERT_IMPL(a_emit_free, ctl.emit, stat.out_free, "result overwrites pending one")
    `FQS_ASSERT_IMPL(a_deq_nonempty, ctl.deq, !stat.empty, "dequeue from empty queue")
    `FQS_ASSERT_NEXT(a_enq_count, ctl.enq_write, count_reg == $past(count_reg) + CW'(1),
                     "enqueue did not bump count")

endmodule

FILE: rtl/fifo_queue_with_search.sv
`timescale 1ns / 1ps
// Top level of the FIFO queue with search: sequencer plus datapath.
// Depends on fqs_pkg, fqs_ctrl, fqs_datapath, fqs_ram.
//
//   channel  handshake            payload
//   cmd      cmd_valid/cmd_stall  command, value
//   rsp      rsp_valid/rsp_stall  status, data_out, last
//
// Enqueue and empty-queue commands: accepted, then a single status reply.
// Call on n entries: one RAM read per entry, each entry listed, then the removal.
// Search on n entries: one RAM read per entry compared, ending at the first match.
// Reset clears head, tail, count and the sequencer; the RAM is not cleared.
// cmd_stall is high while a command runs; rsp_stall freezes a call's walk.
module fifo_queue_with_search #(
    parameter int DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  fqs_pkg::command_t                 command,
    input  logic signed [fqs_pkg::DATA_W-1:0] value,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output fqs_pkg::status_t                  status,
    output logic signed [fqs_pkg::DATA_W-1:0] data_out,
    output logic                              last
);
    import fqs_pkg::*;

    fqs_ctl_t  ctl;
    fqs_stat_t stat;

    fqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .command  (command),
        .stat     (stat),
        .ctl      (ctl)
    );

    fqs_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .ctl      (ctl),
        .stat     (stat),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status   (status),
        .data_out (data_out),
        .last     (last)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for fifo_queue_with_search: directed table, then random command traffic.
// Replies are checked against an in-bench ring model; depends on fqs_pkg and the RTL.
module tb_top;
    import fqs_pkg::*;

    localparam int          QDEPTH      = 32;
    localparam int unsigned RAND_ITEMS  = 200;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned TAIL_CYCLES = 64;

    localparam command_t CMD_UNUSED = 2'd3;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        status_t st;
        word_t   data;
        logic    fin;
    } reply_t;

    typedef struct {
        command_t op;
        word_t    arg;
        bit       fixed;
        status_t  st;
        word_t    data;
    } dir_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    command_t command   = CMD_ENQ;
    word_t    value     = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    status_t  status;
    word_t    data_out;
    logic     last;

    // typed expectation riding along with the command payload
    logic     fixed_on     = 1'b0;
    status_t  fixed_status = ST_STORED;
    word_t    fixed_data   = '0;

    word_t       mirror_store [QDEPTH];
    int unsigned mirror_head  = 0;
    int unsigned mirror_tail  = 0;
    int unsigned mirror_count = 0;
    reply_t      due_replies [$];

    int unsigned fill_level  = 0;
    int unsigned items_sent  = 0;
    word_t       recent_keys [$];
    int unsigned hold_seq    = 0;
    int unsigned idle_cycles = 0;
    int unsigned fault_count = 0;

    dir_row_t dir_rows [24] = '{
        '{CMD_CALL,   32'sd0,        1'b1, ST_EMPTY,    32'sd0},
        '{CMD_SRCH,   WORD_MIN,      1'b1, ST_EMPTY,    32'sd0},
        '{CMD_UNUSED, 32'sh5A5AA5A5, 1'b0, ST_STORED,   32'sd0},
        '{CMD_ENQ,    WORD_MAX,      1'b1, ST_STORED,   32'sd0},
        '{CMD_ENQ,    WORD_MIN,      1'b1, ST_STORED,   32'sd0},
        '{CMD_ENQ,    32'sd0,        1'b1, ST_STORED,   32'sd0},
        '{CMD_ENQ,    -32'sd1,       1'b1, ST_STORED,   32'sd0},
        '{CMD_SRCH,   WORD_MIN,      1'b0, ST_STORED,   32'sd0},
        '{CMD_SRCH,   -32'sd1,       1'b0, ST_STORED,   32'sd0},
        '{CMD_SRCH,   WORD_MAX,      1'b0, ST_STORED,   32'sd0},
        '{CMD_SRCH,   32'sd1,        1'b1, ST_NOTFOUND, 32'sd0},
        '{CMD_UNUSED, -32'sd1,       1'b0, ST_STORED,   32'sd0},
        '{CMD_CALL,   32'sd0,        1'b0, ST_STORED,   32'sd0},
        '{CMD_SRCH,   WORD_MAX,      1'b1, ST_NOTFOUND, 32'sd0},
        '{CMD_CALL,   32'sd0,        1'b0, ST_STORED,   32'sd0},
        '{CMD_CALL,   32'sd0,        1'b0, ST_STORED,   32'sd0},
        '{CMD_CALL,   32'sd0,        1'b0, ST_STORED,   32'sd0},
        '{CMD_CALL,   32'sd0,        1'b1, ST_EMPTY,    32'sd0},
        '{CMD_ENQ,    32'sd1,        1'b1, ST_STORED,   32'sd0},
        '{CMD_ENQ,    32'sd1,        1'b1, ST_STORED,   32'sd0},
        '{CMD_SRCH,   32'sd1,        1'b0, ST_STORED,   32'sd0},
        '{CMD_CALL,   32'sd0,        1'b0, ST_STORED,   32'sd0},
        '{CMD_CALL,   32'sd0,        1'b0, ST_STORED,   32'sd0},
        '{CMD_SRCH,   32'sd1,        1'b1, ST_EMPTY,    32'sd0}
    };

    fifo_queue_with_search #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .command  (command),
        .value    (value),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status   (status),
        .data_out (data_out),
        .last     (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic reply_t make_reply(input status_t s, input word_t d, input logic f);
        return '{s, d, f};
    endfunction

    function automatic void predict_replies(input command_t op, input word_t arg);
        int unsigned p;
        bit hit;
        hit = 1'b0;
        case (op)
            CMD_ENQ:
                if (mirror_count >= QDEPTH)
                    due_replies.push_back(make_reply(ST_FULL, '0, 1'b1));
                else
                begin
                    mirror_store[mirror_tail] = arg;
                    mirror_tail = (mirror_tail + 1) % QDEPTH;
                    mirror_count++;
                    due_replies.push_back(make_reply(ST_STORED, '0, 1'b1));
                end
            CMD_CALL:
                if (mirror_count == 0)
                    due_replies.push_back(make_reply(ST_EMPTY, '0, 1'b1));
                else
                begin
                    p = mirror_head;
                    repeat (mirror_count)
                    begin
                        due_replies.push_back(make_reply(ST_LISTED, mirror_store[p], 1'b0));
                        p = (p + 1) % QDEPTH;
                    end
                    due_replies.push_back(make_reply(ST_REMOVED, mirror_store[mirror_head], 1'b1));
                    mirror_head = (mirror_head + 1) % QDEPTH;
                    mirror_count--;
                end
            CMD_SRCH:
                if (mirror_count == 0)
                    due_replies.push_back(make_reply(ST_EMPTY, '0, 1'b1));
                else
                begin
                    p = mirror_head;
                    for (int i = 0; i < mirror_count && !hit; i++)
                    begin
                        if (mirror_store[p] == arg)
                            hit = 1'b1;
                        else
                            p = (p + 1) % QDEPTH;
                    end
                    if (hit)
                        due_replies.push_back(make_reply(ST_FOUND, mirror_store[p], 1'b1));
                    else
                        due_replies.push_back(make_reply(ST_NOTFOUND, '0, 1'b1));
                end
            default: ;
        endcase
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return word_t'($urandom_range(0, 7));
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic word_t search_key();
        if (recent_keys.size() != 0 && $urandom_range(0, 9) < 7)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return rand_word();
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic offer(input command_t op, input word_t arg, input bit fixed = 1'b0,
                         input status_t st = ST_STORED, input word_t data = '0);
        int unsigned gap;
        cmd_valid    <= 1'b1;
        command      <= op;
        value        <= arg;
        fixed_on     <= fixed;
        fixed_status <= st;
        fixed_data   <= data;
        do @(posedge clk); while (cmd_stall);
        if (op == CMD_ENQ)
        begin
            if (fill_level < QDEPTH)
                fill_level++;
            recent_keys.push_back(arg);
            if (recent_keys.size() > 48)
                void'(recent_keys.pop_front());
        end
        else if (op == CMD_CALL && fill_level > 0)
            fill_level--;
        if (op != CMD_UNUSED)
            items_sent++;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                moved = 1'b1;
                predict_replies(command, value);
                if (fixed_on)
                    due_replies[due_replies.size() - 1] = make_reply(fixed_status, fixed_data, 1'b1);
            end
            if (rsp_valid && !rsp_stall)
            begin
                moved = 1'b1;
                got = make_reply(status, data_out, last);
                if (due_replies.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected transfer: status %0d data %0d last %0b",
                                 status, data_out, last);
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (got.st !== want.st || got.data !== want.data || got.fin !== want.fin)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch: expected status %0d data %0d last %0b,",
                                     want.st, want.data, want.fin,
                                     " got status %0d data %0d last %0b",
                                     got.st, got.data, got.fin);
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // response side: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned pick;
        int unsigned span;
        int unsigned hold_seen;
        hold_seen = 0;
        forever
        begin
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                rsp_stall <= 1'b1;
                span = HOLD_CYCLES;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    rsp_stall <= 1'b0;
                    span = 1;
                end
                else if (pick < 80)
                begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end
                else if (pick < 94)
                begin
                    rsp_stall <= 1'b0;
                    span = $urandom_range(20, 60);
                end
                else
                begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(8, 30);
                end
            end
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        int unsigned burst;
        int unsigned kind;
        int unsigned seq_idx;
        bit hold_done;
        hold_done = 1'b0;
        seq_idx = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer(dir_rows[i].op, dir_rows[i].arg, dir_rows[i].fixed,
                  dir_rows[i].st, dir_rows[i].data);

        // random traffic; the first sequence always fills the queue past full
        items_sent = 0;
        while (items_sent < RAND_ITEMS)
        begin
            pick = (seq_idx == 0) ? 0 : $urandom_range(0, 99);
            if (pick < 12)
            begin
                burst = QDEPTH - fill_level + $urandom_range(1, 3);
                repeat (burst) offer(CMD_ENQ, rand_word());
            end
            else if (pick < 22)
            begin
                burst = fill_level + 1;
                repeat (burst) offer(CMD_CALL, rand_word());
            end
            else if (pick < 92)
            begin
                burst = $urandom_range(4, 12);
                repeat (burst)
                begin
                    kind = $urandom_range(0, 99);
                    if (kind < 40)
                        offer(CMD_ENQ, rand_word());
                    else if (kind < 65)
                        offer(CMD_CALL, rand_word());
                    else
                        offer(CMD_SRCH, search_key());
                end
            end
            else
                offer(CMD_UNUSED, rand_word());
            if (!hold_done && items_sent >= 90)
            begin
                hold_seq <= hold_seq + 1;
                hold_done = 1'b1;
            end
            seq_idx++;
        end
        cmd_valid <= 1'b0;

        @(negedge clk);
        while (due_replies.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/fqs_pkg.sv
rtl/fqs_ram.sv
rtl/fqs_ctrl.sv
rtl/fqs_datapath.sv
rtl/fifo_queue_with_search.sv
sim/tb_top.sv
